// ===== rtl/dist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dist_pkg
// constants, types and helpers for the distortion effect chain
// ----------------------------------------------------------------------------
package dist_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int DIV_STEPS    = 25;

    localparam logic signed [31:0] Q24_ONE   = 32'sd16777216;
    localparam logic signed [30:0] K_DC      = 31'sd16693330;
    localparam logic signed [30:0] K_BASS    = 31'sd838861;
    localparam logic signed [30:0] K_BASSREM = 31'sd15938355;
    localparam logic signed [31:0] T_HARD    = 32'sd11744051;
    localparam logic signed [31:0] T_MED     = 32'sd14260634;
    localparam logic signed [31:0] SOFT_MAX  = 32'sd12777360;
    localparam logic signed [30:0] K_MED     = 31'sd13421773;
    localparam logic signed [24:0] K_TONE0   = 25'sd5033165;
    localparam logic signed [30:0] K_TONE1   = 31'sd11576279;
    localparam logic signed [30:0] K_GAIN    = 31'sd99;
    localparam logic [29:0]        Q24_27    = 30'd452984832;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_TONE  = 3'd1;
    localparam logic [2:0] REG_BASS  = 3'd2;
    localparam logic [2:0] REG_LEVEL = 3'd3;
    localparam logic [2:0] REG_MIX   = 3'd4;
    localparam logic [2:0] REG_CLIP  = 3'd5;

    localparam logic [1:0] CLIP_HARD = 2'd0;
    localparam logic [1:0] CLIP_MED  = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        ST_DC, ST_BASS_A, ST_BASS_B, ST_BOOST, ST_GAIN_K, ST_GAIN, ST_MED,
        ST_SQ, ST_NUM, ST_TONE_K, ST_TONE_A, ST_TONE_B, ST_MIX_A, ST_MIX_B,
        ST_LEVEL
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] hard_clip(input logic signed [31:0] v,
                                                     input logic signed [31:0] t);
        logic signed [31:0] r;
        if (v > t)
        begin
            r = t;
        end
        else if (v < -t)
        begin
            r = -t;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/distortion_effect_chain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distortion_effect_chain_top
// guitar distortion: dc high-pass, bass shelf, gain, clipping, tone, mix, level
// ----------------------------------------------------------------------------
// usage
// input channel in_valid/in_stall carries one audio_in sample per item; output
// channel out_valid/out_stall returns one audio_out sample per item.
// the user must write knobs through cfg_write_en/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. all arithmetic runs on one
// shared 32x31 signed multiplier under a step sequencer: each multiply presents
// its operands, then uses the registered product. soft clip modes add the
// square, the numerator and a restoring divider to the hard clip steps, and
// skip them when the scaled value lies beyond one. in_stall stays high from
// the accept until the result has been taken.
// reset clears the filter state and loads the default knob values.
// when out_stall is high the result is held and no new item is accepted.
// ----------------------------------------------------------------------------
module distortion_effect_chain_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [dist_pkg::SAMPLE_WIDTH-1:0]  audio_in,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [dist_pkg::SAMPLE_WIDTH-1:0]  audio_out,
    input  logic                                      cfg_write_en,
    input  logic [2:0]                                cfg_index,
    input  logic [15:0]                               cfg_data
);
    import dist_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   phase_reg;

    logic [15:0] gain_knob_reg, tone_knob_reg, bass_knob_reg, level_knob_reg;
    logic [15:0] mix_knob_reg;
    logic [1:0]  clip_mode_reg;

    logic signed [SAMPLE_WIDTH-1:0] last_reg, last_next;
    logic signed [SAMPLE_WIDTH:0]   x_reg;
    logic signed [31:0] bt_reg, bt_next, tt_reg, tt_next;
    logic signed [31:0] hp_reg, hp_next, v_reg, v_next;
    logic signed [63:0] acc_reg, acc_next, prod_reg;
    logic signed [24:0] alpha_reg, alpha_next;
    logic [29:0] den_reg, den_next, rem_reg, rem_next;
    logic [24:0] dq_reg, dq_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg, out_next;

    logic signed [31:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [62:0] mul_p;

    logic signed [63:0] ps24, ps16, ps17, mag, ysum;
    logic signed [31:0] vs, sv;
    logic [30:0] rem2;
    logic        ge;
    logic [24:0] qv;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign audio_out = out_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_DC:
            begin
                mul_a = 32'($signed({last_reg, 1'b0}));
                mul_b = K_DC;
            end
            ST_BASS_A: begin mul_a = bt_reg;                 mul_b = K_BASSREM;    end
            ST_BASS_B: begin mul_a = hp_reg;                 mul_b = K_BASS;       end
            ST_BOOST:
            begin
                mul_a = bt_reg;
                mul_b = 31'($signed({~bass_knob_reg[15], bass_knob_reg[14:0], 1'b0}));
            end
            ST_GAIN_K: begin mul_a = $signed({16'd0, gain_knob_reg}); mul_b = K_GAIN; end
            ST_GAIN:   begin mul_a = v_reg; mul_b = $signed({6'd0, acc_reg[24:0]}); end
            ST_MED:    begin mul_a = v_reg; mul_b = K_MED;                          end
            ST_SQ:     begin mul_a = v_reg; mul_b = v_reg[30:0];                    end
            ST_NUM:
            begin
                mul_a = v_reg;
                mul_b = $signed({1'b0, Q24_27 + 30'(acc_reg[24:0])});
            end
            ST_TONE_K: begin mul_a = $signed({16'd0, tone_knob_reg}); mul_b = K_TONE1; end
            ST_TONE_A: begin mul_a = v_reg;  mul_b = 31'(alpha_reg);                 end
            ST_TONE_B: begin mul_a = tt_reg; mul_b = 31'(Q24_ONE) - 31'(alpha_reg);  end
            ST_MIX_A:
            begin
                mul_a = 32'(x_reg);
                mul_b = 31'sd65536 - $signed({15'd0, mix_knob_reg});
            end
            ST_MIX_B:  begin mul_a = tt_reg; mul_b = $signed({15'd0, mix_knob_reg});   end
            ST_LEVEL:  begin mul_a = v_reg;  mul_b = $signed({15'd0, level_knob_reg}); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        bt_next    = bt_reg;
        tt_next    = tt_reg;
        hp_next    = hp_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        alpha_next = alpha_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        ps24 = prod_reg >>> 24;
        ps16 = prod_reg >>> 16;
        ps17 = prod_reg >>> 17;
        ysum = (acc_reg + prod_reg) >>> 16;
        mag  = prod_reg[63] ? -prod_reg : prod_reg;
        vs   = sat32(ps16);
        sv   = '0;
        rem2 = {rem_reg, dq_reg[24]};
        ge   = (rem2 >= {1'b0, den_reg});
        qv   = {dq_reg[23:0], ge};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC;
                    step_next  = ST_DC;
                end
            end
            S_CALC:
            begin
                if (phase_reg)
                begin
                    case (step_reg)
                        ST_DC:
                        begin
                            hp_next   = sat32(64'(x_reg) - ps24);
                            last_next = x_reg[SAMPLE_WIDTH:1];
                            step_next = ST_BASS_A;
                        end
                        ST_BASS_A: begin acc_next = ps24; step_next = ST_BASS_B; end
                        ST_BASS_B:
                        begin
                            bt_next   = sat32(acc_reg + ps24);
                            step_next = ST_BOOST;
                        end
                        ST_BOOST:
                        begin
                            v_next    = sat32(64'(hp_reg) + ps16);
                            step_next = ST_GAIN_K;
                        end
                        ST_GAIN_K:
                        begin
                            acc_next  = prod_reg + 64'sd65536;
                            step_next = ST_GAIN;
                        end
                        ST_GAIN, ST_MED:
                        begin
                            if (step_reg == ST_MED)
                            begin
                                sv = ps24[31:0];
                            end
                            else
                            begin
                                sv = vs >>> 1;
                            end
                            if (step_reg == ST_GAIN && clip_mode_reg == CLIP_HARD)
                            begin
                                v_next    = hard_clip(vs, T_HARD);
                                step_next = ST_TONE_K;
                            end
                            else if (step_reg == ST_GAIN && clip_mode_reg == CLIP_MED)
                            begin
                                v_next    = hard_clip(vs, T_MED);
                                step_next = ST_MED;
                            end
                            else if (sv > Q24_ONE)
                            begin
                                v_next    = SOFT_MAX;
                                step_next = ST_TONE_K;
                            end
                            else if (sv < -Q24_ONE)
                            begin
                                v_next    = -SOFT_MAX;
                                step_next = ST_TONE_K;
                            end
                            else
                            begin
                                v_next    = sv;
                                step_next = ST_SQ;
                            end
                        end
                        ST_SQ: begin acc_next = ps24; step_next = ST_NUM; end
                        ST_NUM:
                        begin
                            den_next   = Q24_27 + {acc_reg[26:0], 3'b000}
                                         + 30'(acc_reg[24:0]);
                            neg_next   = prod_reg[63];
                            rem_next   = mag[54:25];
                            dq_next    = mag[24:0];
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                        ST_TONE_K:
                        begin
                            alpha_next = K_TONE0 + ps16[24:0];
                            step_next  = ST_TONE_A;
                        end
                        ST_TONE_A: begin acc_next = ps24; step_next = ST_TONE_B; end
                        ST_TONE_B:
                        begin
                            tt_next   = sat32(acc_reg + ps24);
                            step_next = ST_MIX_A;
                        end
                        ST_MIX_A: begin acc_next = prod_reg; step_next = ST_MIX_B; end
                        ST_MIX_B:
                        begin
                            v_next    = sat32(ysum);
                            step_next = ST_LEVEL;
                        end
                        ST_LEVEL:
                        begin
                            if (ps17 > 64'sd8388607)
                            begin
                                out_next = 24'sh7fffff;
                            end
                            else if (ps17 < -64'sd8388608)
                            begin
                                out_next = 24'sh800000;
                            end
                            else
                            begin
                                out_next = ps17[SAMPLE_WIDTH-1:0];
                            end
                            state_next = S_DONE;
                        end
                        default: step_next = ST_DC;
                    endcase
                end
            end
            S_DIV:
            begin
                rem_next = ge ? 30'(rem2 - {1'b0, den_reg}) : rem2[29:0];
                dq_next  = qv;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    v_next     = neg_reg ? -32'($signed({1'b0, qv}))
                                         : 32'($signed({1'b0, qv}));
                    state_next = S_CALC;
                    step_next  = ST_TONE_K;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= ST_DC;
            phase_reg      <= 1'b0;
            gain_knob_reg  <= 16'd32768;
            tone_knob_reg  <= 16'd39322;
            bass_knob_reg  <= 16'd32768;
            level_knob_reg <= 16'd45875;
            mix_knob_reg   <= 16'd65535;
            clip_mode_reg  <= CLIP_HARD;
            last_reg       <= '0;
            bt_reg         <= '0;
            tt_reg         <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= (state_reg == S_CALC) ? ~phase_reg : 1'b0;
            last_reg  <= last_next;
            bt_reg    <= bt_next;
            tt_reg    <= tt_next;
            cnt_reg   <= cnt_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_GAIN:  gain_knob_reg  <= cfg_data;
                    REG_TONE:  tone_knob_reg  <= cfg_data;
                    REG_BASS:  bass_knob_reg  <= cfg_data;
                    REG_LEVEL: level_knob_reg <= cfg_data;
                    REG_MIX:   mix_knob_reg   <= cfg_data;
                    REG_CLIP:  clip_mode_reg  <= cfg_data[1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            x_reg <= {audio_in, 1'b0};
        end
        prod_reg  <= {mul_p[62], mul_p};
        hp_reg    <= hp_next;
        v_reg     <= v_next;
        acc_reg   <= acc_next;
        alpha_reg <= alpha_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        neg_reg   <= neg_next;
        out_reg   <= out_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CALC && step_reg == ST_DC && !phase_reg))
        else $error("accepted item did not start the sequence");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < 5'(DIV_STEPS)))
        else $error("divider ran past its step count");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> (state_reg == S_DIV ||
                                  (state_reg == S_CALC && step_reg == ST_TONE_K)))
        else $error("divider left to the wrong step");

endmodule

// ===== tb/tb_distortion_effect_chain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distortion_effect_chain_top
// self-checking bench for the distortion effect chain: samples go through a
// bit-exact fixed-point predictor of the dc high-pass, bass shelf, gain,
// clipping, tone filter, mix and level stages, and every output item is
// compared with the oldest predicted sample. knobs change between phases
// while the block is idle; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_distortion_effect_chain_top;
    import dist_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam longint     Q24_MAXV  = 64'sd2147483647;
    localparam longint     Q24_MINV  = -64'sd2147483648;
    localparam longint     OUT_LIM   = 64'sd1 << (SAMPLE_WIDTH - 1);

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [SAMPLE_WIDTH-1:0]  audio_in;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [SAMPLE_WIDTH-1:0]  audio_out;
    logic                            cfg_write_en;
    logic [2:0]                      cfg_index;
    logic [15:0]                     cfg_data;

    longint gain_k, tone_k, bass_k, level_k, mix_k, clip_sel;
    longint prev_sample, bass_lp, tone_lp;
    logic signed [SAMPLE_WIDTH-1:0] pending_samples[$];
    int     mismatches;
    bit     no_idle;
    int     stall_left;

    distortion_effect_chain_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .audio_in     (audio_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .audio_out    (audio_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_q824(longint v);
        if (v > Q24_MAXV)
        begin
            return Q24_MAXV;
        end
        if (v < Q24_MINV)
        begin
            return Q24_MINV;
        end
        return v;
    endfunction

    function automatic longint mul_q24(longint a, longint b);
        return floor_sh(a * b, 24);
    endfunction

    function automatic longint limit_q824(longint v, longint t);
        if (v > t)
        begin
            return t;
        end
        if (v < -t)
        begin
            return -t;
        end
        return v;
    endfunction

    function automatic longint rational_tanh(longint v);
        longint sq;
        longint one;
        longint k27;
        one = longint'(Q24_ONE);
        k27 = longint'(Q24_27);
        if (v > one)
        begin
            return longint'(SOFT_MAX);
        end
        if (v < -one)
        begin
            return -longint'(SOFT_MAX);
        end
        sq = mul_q24(v, v);
        return (v * (k27 + sq)) / (k27 + 9 * sq);
    endfunction

    // advances the filter state by one sample and returns the processed sample
    function automatic logic signed [SAMPLE_WIDTH-1:0] distort_sample(
        logic signed [SAMPLE_WIDTH-1:0] smp);
        longint x, hp, v, shaped, alpha, mixed, y;
        x = longint'(smp) * 2;
        hp = sat_q824(x - mul_q24(prev_sample * 2, longint'(K_DC)));
        prev_sample = longint'(smp);
        bass_lp = sat_q824(mul_q24(bass_lp, longint'(K_BASSREM)) +
                           mul_q24(hp, longint'(K_BASS)));
        v = sat_q824(hp + floor_sh(bass_lp * ((bass_k - 32768) * 2), 16));
        v = sat_q824(floor_sh(v * (65536 + gain_k * 99), 16));
        if (clip_sel == longint'(CLIP_HARD))
        begin
            shaped = limit_q824(v, longint'(T_HARD));
        end
        else if (clip_sel == longint'(CLIP_MED))
        begin
            shaped = rational_tanh(mul_q24(limit_q824(v, longint'(T_MED)), longint'(K_MED)));
        end
        else
        begin
            shaped = rational_tanh(floor_sh(v, 1));
        end
        alpha = longint'(K_TONE0) + floor_sh(tone_k * longint'(K_TONE1), 16);
        tone_lp = sat_q824(mul_q24(alpha, shaped) +
                           mul_q24(longint'(Q24_ONE) - alpha, tone_lp));
        mixed = sat_q824(floor_sh(x * (65536 - mix_k) + tone_lp * mix_k, 16));
        y = floor_sh(floor_sh(mixed * level_k, 16), 1);
        if (y > OUT_LIM - 1)
        begin
            y = OUT_LIM - 1;
        end
        if (y < -OUT_LIM)
        begin
            y = -OUT_LIM;
        end
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    // output side: random stall and comparison
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [SAMPLE_WIDTH-1:0] want;
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 40)
                    begin
                        $display("%0t: unexpected item, expected none, actual %0d",
                                 $time, audio_out);
                    end
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (audio_out !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 40)
                        begin
                            $display("%0t: audio_out expected %0d actual %0d",
                                     $time, want, audio_out);
                        end
                    end
                end
            end
            if (no_idle)
            begin
                out_stall <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    out_stall <= 1'b0;
                end
                else
                begin
                    out_stall <= 1'b1;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] smp);
        int r;
        int gap;
        in_valid <= 1'b1;
        audio_in <= smp;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_samples.push_back(distort_sample(smp));
        r = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle)
        begin
            if (r >= 95)
            begin
                gap = $urandom_range(10, 60);
            end
            else if (r >= 60)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_knob(logic [2:0] idx, logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAIN:  gain_k   = longint'(val);
            REG_TONE:  tone_k   = longint'(val);
            REG_BASS:  bass_k   = longint'(val);
            REG_LEVEL: level_k  = longint'(val);
            REG_MIX:   mix_k    = longint'(val);
            REG_CLIP:  clip_sel = longint'(val & 16'd3);
            default:   ;
        endcase
    endtask

    task automatic write_all_knobs(logic [15:0] g, logic [15:0] t, logic [15:0] b,
                                   logic [15:0] l, logic [15:0] m, logic [15:0] c);
        write_knob(REG_GAIN, g);
        write_knob(REG_TONE, t);
        write_knob(REG_BASS, b);
        write_knob(REG_LEVEL, l);
        write_knob(REG_MIX, m);
        write_knob(REG_CLIP, c);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return SAMPLE_WIDTH'($urandom());
        end
        if (r < 80)
        begin
            return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
        end
        if (r < 90)
        begin
            return (r[0]) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        return $signed(24'($urandom_range(0, 1048575))) - 24'sd524288;
    endfunction

    function automatic logic [15:0] random_knob();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 16'd0;
        end
        if (r == 1)
        begin
            return 16'hffff;
        end
        return 16'($urandom());
    endfunction

    task automatic test_reset_defaults();
        send_sample(24'sd0);
        send_sample({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        send_sample(-24'sd1);
        send_sample(24'sd1);
        wait_idle();
    endtask

    task automatic test_clip_modes();
        logic [15:0] mode_val;
        for (int m = 0; m < 4; m++)
        begin
            mode_val = 16'(m);
            if (m == 3)
            begin
                mode_val = 16'hffff;
            end
            write_knob(REG_CLIP, mode_val);
            write_knob(REG_GAIN, (m[0]) ? 16'hffff : 16'd0);
            send_sample({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
            send_sample({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
            send_sample(24'sd3000);
            send_sample(24'sd0);
            wait_idle();
        end
        write_knob(REG_SPARE, 16'hffff);
        write_knob(REG_SPARE + 3'd1, 16'h0000);
    endtask

    task automatic test_knob_extremes();
        write_all_knobs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'(CLIP_HARD));
        send_sample({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        send_sample(-24'sd77777);
        wait_idle();
        write_all_knobs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'(CLIP_MED));
        send_sample({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
        send_sample(24'sd77777);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 14; p++)
        begin
            no_idle = (p % 5 == 2);
            write_all_knobs(random_knob(), random_knob(), random_knob(), random_knob(),
                            random_knob(), 16'($urandom_range(0, 3)));
            for (int i = 0; i < 95; i++)
            begin
                send_sample(random_sample());
            end
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        audio_in     = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        no_idle      = 1'b0;
        gain_k       = 32768;
        tone_k       = 39322;
        bass_k       = 32768;
        level_k      = 45875;
        mix_k        = 65535;
        clip_sel     = 0;
        prev_sample  = 0;
        bass_lp      = 0;
        tone_lp      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_clip_modes();
        test_knob_extremes();
        test_random_phases();
        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_samples.size() == 0)
        begin
            $display("distortion_effect_chain_top regression: pass");
        end
        else
        begin
            $display("distortion_effect_chain_top regression: fail");
        end
        $finish;
    end

    initial
    begin
        #50ms;
        $display("distortion_effect_chain_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dist_pkg.sv
rtl/distortion_effect_chain_top.sv
tb/tb_distortion_effect_chain_top.sv
